>>> rtl/core/fr_pkg.sv
package fr_pkg;

  // Field widths of the request and result items
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PosW   = 11;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned SumW   = 32;

  // Walk index: one bit above a position so that a climb step cannot wrap
  localparam int unsigned IdxW   = PosW + 1;

  // Active size after reset
  localparam logic [PosW-1:0] SizeReset = PosW'(1024);

  // Request modes
  localparam logic [ModeW-1:0] MODE_ADD   = 2'd0;
  localparam logic [ModeW-1:0] MODE_QUERY = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_RIGHT,
    ST_Q_LEFT,
    ST_Q_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_add;    // latch an add request, walk starts at position
    logic load_query;  // latch a query request, walk starts at clamped right end
    logic load_below;  // switch the walk to the lower prefix
    logic rd_walk;     // read node at index and step down
    logic walk_sub;    // that read is subtracted
    logic add_wr;      // write node plus amount and step up
    logic clr_init;    // restart the clearing sweep
    logic clr_wr;      // zero one node of the sweep
    logic out_load;    // move the sum into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic x_zero;      // walk index is zero
    logic add_stop;    // climb has left the active range
    logic clr_last;    // sweep is at the last node
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

>>> rtl/core/fenwick_range_sum.sv
// Binary indexed tree of 32-bit wrapping sums over positions 1..size, where size is
// active_size capped at MAX_POSITIONS. Mode 0 adds the sign-extended delta along the
// climb from position; mode 1 returns sum(left_end..position) as two prefix walks;
// mode 2 zeroes every node; mode 3 is ignored. Nodes sit in one single-port-read RAM
// with registered read, so one request is in work at a time: an add reads and then
// writes each node on its climb, a query reads each node on both prefix paths, and a
// clear writes every node in turn. After reset the same clearing pass runs over every
// node before the first request is taken; configuration writes are taken meanwhile. A
// finished sum waits in the output register while the next request is taken.
module fenwick_range_sum #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fr_pkg::PosW-1:0]           cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fr_pkg::ModeW-1:0]          mode_i,
  input  logic [fr_pkg::PosW-1:0]           position_i,
  input  logic [fr_pkg::PosW-1:0]           left_end_i,
  input  logic signed [fr_pkg::DeltaW-1:0]  delta_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fr_pkg::SumW-1:0]    range_sum_o
);

  fr_pkg::ctrl_cmd_t  cmd;
  fr_pkg::dp_status_t status;

  // Sequencer
  fr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Node store, walk index and accumulator
  fr_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .position_i  (position_i),
    .left_end_i  (left_end_i),
    .delta_i     (delta_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .range_sum_o (range_sum_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> rtl/core/fr_ram.sv
module fr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fr_ctrl.sv
module fr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fr_pkg::ModeW-1:0]    mode_i,
  input  fr_pkg::dp_status_t          status_i,
  output fr_pkg::ctrl_cmd_t           cmd_o
);

  fr_pkg::state_e state_q, state_d;

  // State register; reset starts with a sweep that zeroes the tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            fr_pkg::MODE_ADD:   state_d = fr_pkg::ST_ADD_RD;
            fr_pkg::MODE_QUERY: state_d = fr_pkg::ST_Q_RIGHT;
            fr_pkg::MODE_CLEAR: state_d = fr_pkg::ST_CLEAR;
            default:            state_d = fr_pkg::ST_IDLE;
          endcase
        end
      end
      fr_pkg::ST_ADD_RD: begin
        state_d = status_i.add_stop ? fr_pkg::ST_IDLE : fr_pkg::ST_ADD_WR;
      end
      fr_pkg::ST_ADD_WR: begin
        state_d = fr_pkg::ST_ADD_RD;
      end
      fr_pkg::ST_Q_RIGHT: begin
        if (status_i.x_zero) begin
          state_d = fr_pkg::ST_Q_LEFT;
        end
      end
      fr_pkg::ST_Q_LEFT: begin
        if (status_i.x_zero) begin
          state_d = fr_pkg::ST_Q_DONE;
        end
      end
      fr_pkg::ST_Q_DONE: begin
        if (status_i.out_free) begin
          state_d = fr_pkg::ST_IDLE;
        end
      end
      fr_pkg::ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = fr_pkg::ST_IDLE;
        end
      end
      default: state_d = fr_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != fr_pkg::ST_IDLE);
    case (state_q)
      fr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_add   = (mode_i == fr_pkg::MODE_ADD);
          cmd_o.load_query = (mode_i == fr_pkg::MODE_QUERY);
          cmd_o.clr_init   = (mode_i == fr_pkg::MODE_CLEAR);
        end
      end
      fr_pkg::ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
      end
      fr_pkg::ST_Q_RIGHT: begin
        cmd_o.rd_walk    = !status_i.x_zero;
        cmd_o.load_below = status_i.x_zero;
      end
      fr_pkg::ST_Q_LEFT: begin
        cmd_o.rd_walk  = !status_i.x_zero;
        cmd_o.walk_sub = 1'b1;
      end
      fr_pkg::ST_Q_DONE: begin
        cmd_o.out_load = status_i.out_free;
      end
      fr_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/core/fr_datapath.sv
module fr_datapath #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fr_pkg::PosW-1:0]           cfg_wdata_i,
  input  logic [fr_pkg::PosW-1:0]           position_i,
  input  logic [fr_pkg::PosW-1:0]           left_end_i,
  input  logic signed [fr_pkg::DeltaW-1:0]  delta_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [fr_pkg::SumW-1:0]    range_sum_o,
  input  fr_pkg::ctrl_cmd_t                 cmd_i,
  output fr_pkg::dp_status_t                status_o
);

  localparam int unsigned AddrW = $clog2(MAX_POSITIONS);
  localparam int unsigned PosW  = fr_pkg::PosW;
  localparam int unsigned IdxW  = fr_pkg::IdxW;
  localparam int unsigned SumW  = fr_pkg::SumW;
  // Largest size that the tree can hold, as a position
  localparam logic [PosW-1:0] SizeCap =
    (MAX_POSITIONS > (2**PosW - 1)) ? {PosW{1'b1}} : PosW'(MAX_POSITIONS);

  logic [PosW-1:0]  active_q;
  logic [PosW-1:0]  size;
  logic [IdxW-1:0]  x_q, x_d;
  logic [IdxW-1:0]  x_low;
  logic [IdxW-1:0]  below_q, below_d;
  logic [SumW-1:0]  amount_q;
  logic [SumW-1:0]  acc_q, acc_d;
  logic             rd_vld_q, sub_q;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic [SumW-1:0]  out_data_q;
  logic [PosW-1:0]  right;
  logic [PosW-1:0]  left_m1;
  logic [PosW-1:0]  below;
  logic [AddrW-1:0] node_addr;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [SumW-1:0]  ram_wdata;
  logic [SumW-1:0]  ram_rdata;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= fr_pkg::SizeReset;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  assign size = (active_q > SizeCap) ? SizeCap : active_q;

  // Query ends, clamped to the size
  assign right   = (position_i > size) ? size : position_i;
  assign left_m1 = (left_end_i == '0) ? '0 : left_end_i - PosW'(1);
  assign below   = (left_m1 > size) ? size : left_m1;

  // Lowest set bit of the walk index
  assign x_low     = x_q & (~x_q + IdxW'(1));
  assign node_addr = AddrW'(x_q - IdxW'(1));

  // Walk index
  always_comb begin
    x_d     = x_q;
    below_d = below_q;
    if (cmd_i.load_add) begin
      x_d = IdxW'(position_i);
    end else if (cmd_i.load_query) begin
      x_d     = IdxW'(right);
      below_d = IdxW'(below);
    end else if (cmd_i.load_below) begin
      x_d = below_q;
    end else if (cmd_i.rd_walk) begin
      x_d = x_q - x_low;
    end else if (cmd_i.add_wr) begin
      x_d = x_q + x_low;
    end
  end

  // Accumulator takes each node in the cycle after its read
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load_query) begin
      acc_d = '0;
    end else if (rd_vld_q) begin
      acc_d = sub_q ? acc_q - ram_rdata : acc_q + ram_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    below_q <= below_d;
    acc_q   <= acc_d;
    if (cmd_i.load_add) begin
      amount_q <= SumW'(delta_i);
    end
  end

  // Read tracking and clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      sub_q    <= 1'b0;
      clr_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_walk;
      sub_q    <= cmd_i.walk_sub;
      clr_q    <= clr_d;
    end
  end

  always_comb begin
    clr_d = clr_q;
    if (cmd_i.clr_init) begin
      clr_d = '0;
    end else if (cmd_i.clr_wr) begin
      clr_d = clr_q + AddrW'(1);
    end
  end

  // Node store write: sweep zeroes, climb writes node plus amount
  always_comb begin
    ram_we    = cmd_i.clr_wr | cmd_i.add_wr;
    ram_waddr = cmd_i.clr_wr ? clr_q : node_addr;
    ram_wdata = cmd_i.clr_wr ? '0 : ram_rdata + amount_q;
  end

  fr_ram #(
    .Width (SumW),
    .Depth (MAX_POSITIONS)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (node_addr),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_data_q;

  // Status
  assign status_o.x_zero   = (x_q == '0);
  assign status_o.add_stop = (x_q == '0) || (x_q > IdxW'(size));
  assign status_o.clr_last = (clr_q == AddrW'(MAX_POSITIONS - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

>>> dv/fenwick_range_sum_checker.sv
`timescale 1ns / 1ps

// Watches both request channels of the range-sum block, keeps its own copy of the
// tree and of the active size, and compares every returned sum in order.
module fenwick_range_sum_checker #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fr_pkg::PosW-1:0]           cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [fr_pkg::ModeW-1:0]          mode_i,
  input  logic [fr_pkg::PosW-1:0]           position_i,
  input  logic [fr_pkg::PosW-1:0]           left_end_i,
  input  logic signed [fr_pkg::DeltaW-1:0]  delta_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [fr_pkg::SumW-1:0]    range_sum_i,
  output int unsigned                       pending_o,
  output int unsigned                       mismatches_o
);

  // Room for sums in flight; the block never holds more than two
  localparam int unsigned SumSlots = 16;

  // Shadow tree, indexed 1..MAX_POSITIONS as in the block
  logic [fr_pkg::SumW-1:0] tree_nodes [1:MAX_POSITIONS];
  logic [fr_pkg::PosW-1:0] size_q;
  logic [fr_pkg::SumW-1:0] expected_sums [SumSlots];
  int unsigned             sums_wr;
  int unsigned             sums_rd;
  logic [fr_pkg::SumW-1:0] expected_sum;

  function automatic int unsigned lowest_bit(int unsigned x);
    return x & (~x + 1);
  endfunction

  // Prefix sum: walk down, dropping the lowest set bit each step
  function automatic logic [fr_pkg::SumW-1:0] prefix_total(int unsigned x);
    logic [fr_pkg::SumW-1:0] acc;
    acc = '0;
    while (x != 0 && x <= MAX_POSITIONS) begin
      acc += tree_nodes[x];
      x -= lowest_bit(x);
    end
    return acc;
  endfunction

  // Append one expected sum behind those still outstanding
  task automatic queue_sum(input logic [fr_pkg::SumW-1:0] sum);
    if (sums_wr - sums_rd >= SumSlots) begin
      mismatches_o++;
      $error("range_sum: expected at most %0d pending, actual %0d", SumSlots,
             sums_wr - sums_rd + 1);
    end else begin
      expected_sums[sums_wr % SumSlots] = sum;
      sums_wr++;
    end
  endtask

  // Apply one accepted request to the shadow tree; a query queues its sum
  task automatic predict_request(input logic [fr_pkg::ModeW-1:0] op,
                                 input logic [fr_pkg::PosW-1:0] pos,
                                 input logic [fr_pkg::PosW-1:0] left,
                                 input logic signed [fr_pkg::DeltaW-1:0] amount);
    int unsigned eff;
    int unsigned x;
    int unsigned right;
    int unsigned below;
    logic [fr_pkg::SumW-1:0] wide_amount;
    eff = (size_q > MAX_POSITIONS) ? MAX_POSITIONS : size_q;
    case (op)
      fr_pkg::MODE_ADD: begin
        wide_amount = {{(fr_pkg::SumW-fr_pkg::DeltaW){amount[fr_pkg::DeltaW-1]}}, amount};
        // out-of-range adds fall straight through the loop test
        x = pos;
        while (x != 0 && x <= eff) begin
          tree_nodes[x] += wide_amount;
          x += lowest_bit(x);
        end
      end
      fr_pkg::MODE_QUERY: begin
        right = (pos > eff) ? eff : pos;
        below = (left == 0) ? 0 : left - 1;
        if (below > eff) below = eff;
        queue_sum(prefix_total(right) - prefix_total(below));
      end
      fr_pkg::MODE_CLEAR: begin
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
      end
      default: ;
    endcase
  endtask

  // Results are checked before the request of the same edge is predicted;
  // a size write takes effect after the request of its edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tree_nodes[i]) tree_nodes[i] = '0;
      size_q = fr_pkg::SizeReset;
      sums_wr = 0;
      sums_rd = 0;
      mismatches_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (sums_wr == sums_rd) begin
          mismatches_o++;
          $error("range_sum: expected none, actual %0d", range_sum_i);
        end else begin
          expected_sum = expected_sums[sums_rd % SumSlots];
          sums_rd++;
          if (range_sum_i !== expected_sum) begin
            mismatches_o++;
            $error("range_sum: expected %0d, actual %0d", $signed(expected_sum), range_sum_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_request(mode_i, position_i, left_end_i, delta_i);
      if (cfg_we_i) size_q = cfg_wdata_i;
      pending_o <= sums_wr - sums_rd;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxPositions  = 1024;
  localparam int unsigned CycleLimit    = 1_000_000;
  // a clear sweeps every node, the slowest thing the block does
  localparam int unsigned SettleCycles  = MaxPositions + 64;
  localparam int unsigned ItemsPerPhase = 200;
  localparam logic [fr_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [fr_pkg::PosW-1:0]          cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [fr_pkg::ModeW-1:0]         mode = '0;
  logic [fr_pkg::PosW-1:0]          position = '0;
  logic [fr_pkg::PosW-1:0]          left_end = '0;
  logic signed [fr_pkg::DeltaW-1:0] delta = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [fr_pkg::SumW-1:0]   range_sum;
  logic                             calm = 1'b0;
  int unsigned                      pending_sums;
  int unsigned                      mismatch_count;
  int unsigned                      cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fenwick_range_sum #(
    .MAX_POSITIONS (MaxPositions)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .position_i  (position),
    .left_end_i  (left_end),
    .delta_i     (delta),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .range_sum_o (range_sum)
  );

  fenwick_range_sum_checker #(
    .MAX_POSITIONS (MaxPositions)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .position_i   (position),
    .left_end_i   (left_end),
    .delta_i      (delta),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .range_sum_i  (range_sum),
    .pending_o    (pending_sums),
    .mismatches_o (mismatch_count)
  );

  // Receiver back-pressure, off during the calm stretch
  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 37);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One request, with a random gap in front; returns at the accepting edge
  task automatic send_request(input logic [fr_pkg::ModeW-1:0] op,
                              input logic [fr_pkg::PosW-1:0] pos,
                              input logic [fr_pkg::PosW-1:0] left,
                              input logic signed [fr_pkg::DeltaW-1:0] amount);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= op;
    position <= pos;
    left_end <= left;
    delta    <= amount;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stop sending, wait for every outstanding sum, then let the block go quiet
  task automatic drain(input int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_sums != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Random traffic at one active size; mostly in-range ends, some anywhere
  task automatic random_phase(input logic [fr_pkg::PosW-1:0] size,
                              input int unsigned calm_items,
                              input int unsigned pause_at);
    int unsigned eff;
    int unsigned r;
    int unsigned pos_val;
    int unsigned left_val;
    logic [fr_pkg::ModeW-1:0] op;
    drain(SettleCycles);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    eff = (size > MaxPositions) ? MaxPositions : size;
    for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
      calm <= (n < calm_items);
      if (n == pause_at) drain(0);
      r = $urandom_range(0, 99);
      if (r < 2)       op = fr_pkg::MODE_CLEAR;
      else if (r < 5)  op = MODE_UNUSED;
      else if (r < 52) op = fr_pkg::MODE_ADD;
      else             op = fr_pkg::MODE_QUERY;
      if (eff != 0 && $urandom_range(0, 99) < 75) pos_val = $urandom_range(1, eff);
      else pos_val = $urandom_range(0, 2047);
      if ($urandom_range(0, 99) < 70) left_val = $urandom_range(0, pos_val + 1);
      else left_val = $urandom_range(0, 2047);
      send_request(op, fr_pkg::PosW'(pos_val), fr_pkg::PosW'(left_val),
                   fr_pkg::DeltaW'($urandom));
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty tree, delta extremes, out-of-range adds, clamped and reversed ends
    send_request(fr_pkg::MODE_QUERY, 11'd1024, 11'd1,    16'sd0);
    send_request(fr_pkg::MODE_ADD,   11'd1,    11'd0,    16'sh7FFF);
    send_request(fr_pkg::MODE_ADD,   11'd1024, 11'd0,    16'sh8000);
    send_request(fr_pkg::MODE_ADD,   11'd1023, 11'd2047, 16'sh5555);
    send_request(fr_pkg::MODE_ADD,   11'd0,    11'd0,    16'sd1234);
    send_request(fr_pkg::MODE_ADD,   11'd1025, 11'd0,    16'sd77);
    send_request(fr_pkg::MODE_ADD,   11'd2047, 11'd0,    -16'sd1);
    send_request(fr_pkg::MODE_QUERY, 11'd1024, 11'd1,    16'sd0);
    send_request(fr_pkg::MODE_QUERY, 11'd2047, 11'd0,    16'sd0);
    send_request(fr_pkg::MODE_QUERY, 11'd1023, 11'd1023, 16'sd0);
    send_request(fr_pkg::MODE_QUERY, 11'd3,    11'd1000, 16'sd0);
    send_request(fr_pkg::MODE_QUERY, 11'd0,    11'd2047, 16'sd0);
    send_request(fr_pkg::MODE_QUERY, 11'd1024, 11'd1025, 16'sd0);
    send_request(fr_pkg::MODE_QUERY, 11'd1,    11'd1,    16'sd0);
    send_request(MODE_UNUSED,        11'd5,    11'd1,    16'sd9);
    send_request(fr_pkg::MODE_QUERY, 11'd512,  11'd2,    16'sd0);
    send_request(fr_pkg::MODE_CLEAR, 11'd7,    11'd3,    16'shFFFF);
    send_request(fr_pkg::MODE_QUERY, 11'd1024, 11'd0,    16'sd0);
    send_request(fr_pkg::MODE_ADD,   11'd512,  11'd0,    16'sh2AAA);
    send_request(fr_pkg::MODE_ADD,   11'd600,  11'd0,    16'shAAAA);
    send_request(fr_pkg::MODE_QUERY, 11'd600,  11'd500,  16'sd0);

    // Random phases; the size changes without a clear in between
    random_phase(11'd1,    0,   ItemsPerPhase);
    random_phase(11'd2047, 0,   ItemsPerPhase);
    random_phase(11'd0,    0,   ItemsPerPhase);
    random_phase(11'd1024, 120, 150);
    random_phase(fr_pkg::PosW'($urandom_range(2, 1023)), 0, ItemsPerPhase);
    random_phase(11'd1000, 0,   ItemsPerPhase);
    random_phase(11'd17,   0,   ItemsPerPhase);

    drain(SettleCycles);
    if (mismatch_count == 0 && pending_sums == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
